/* hw/rtl/lpht_pkg.sv */
// ----------------------------------------------------------------------------
// lpht_pkg
// Shared types and constants of the linear probing hash table unit.
// ----------------------------------------------------------------------------
package lpht_pkg;

  localparam int SLOTS      = 1021;
  localparam int KEY_BITS   = 32;
  localparam int VALUE_BITS = 32;
  localparam int POS_W      = $clog2(SLOTS);
  localparam int ADDR_W     = $clog2(2 * SLOTS);
  localparam int DEPTH      = 2 * SLOTS;
  localparam int CNT_W      = 11;
  localparam int HALF       = SLOTS / 2;
  // 2^POS_W reduced modulo SLOTS, used to fold the upper key bits.
  localparam int FOLD_K     = (2 ** POS_W) % SLOTS;

  typedef enum logic [1:0] {
    TAG_EMPTY = 2'd0,
    TAG_LIVE  = 2'd1,
    TAG_TOMB  = 2'd2
  } tag_e;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_LOOKUP = 2'd2,
    REQ_LOOKUP_ALT = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_DUPLICATE = 3'd2,
    ST_FULL      = 3'd3,
    ST_UNUSED    = 3'd4
  } status_e;

  typedef struct packed {
    tag_e                  tag;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] val;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

endpackage

/* hw/rtl/lpht_ram.sv */
// ----------------------------------------------------------------------------
// lpht_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module lpht_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(Depth)-1:0] wr_addr_i,
  input  logic [Width-1:0]         wr_data_i,
  input  logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic [Width-1:0]         rd_data_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_data_o <= mem[rd_addr_i];
  end

endmodule

/* hw/rtl/lpht_mod.sv */
// ----------------------------------------------------------------------------
// lpht_mod
// Iterative reduction of a key modulo the slot count by folding high bits.
// ----------------------------------------------------------------------------
module lpht_mod import lpht_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [KEY_BITS-1:0] key_i,
  output logic                done_o,
  output logic [POS_W-1:0]    pos_o
);

  logic [KEY_BITS-1:0] x_q, x_d;
  logic                run_q;
  logic                in_range;

  // Each pass replaces hi * 2^POS_W + lo by hi * FOLD_K + lo, same residue.
  assign x_d   = KEY_BITS'((x_q >> POS_W) * FOLD_K) + KEY_BITS'(x_q[POS_W-1:0]);
  assign in_range = x_q < KEY_BITS'(2 * SLOTS);
  assign done_o = run_q && in_range;
  assign pos_o = (x_q >= KEY_BITS'(SLOTS)) ? POS_W'(x_q - KEY_BITS'(SLOTS))
                                           : POS_W'(x_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
    end else if (start_i) begin
      run_q <= 1'b1;
    end else if (in_range) begin
      run_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q <= key_i;
    end else if (run_q && !in_range) begin
      x_q <= x_d;
    end
  end

endmodule

/* hw/rtl/linear_probe_hash_table_unit.sv */
// ----------------------------------------------------------------------------
// linear_probe_hash_table_unit
// Key-to-value table with open addressing, linear probing and tombstones.
// ----------------------------------------------------------------------------
// One request is taken at a time. A request first reduces the key to its home
// slot, then checks the counts and starts the first slot read, then visits the
// slots on the probe chain, and finally hands over the result. All slots live
// in one RAM of two banks with a registered read, and the probe walk of that
// single read port sets the rate. When live entries plus tombstones pass half
// the slots, an insert first rebuilds the table into the other bank: a clear
// of that bank, then a scan of every slot with a re-probe for each live entry.
// After reset a clearing pass empties both banks before the first request is
// taken.
module linear_probe_hash_table_unit import lpht_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  req_type_i,
  input  logic [31:0] key_i,
  input  logic [31:0] value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic        found_o,
  output logic [31:0] value_out_o,
  output logic [9:0]  live_count_o
);

  typedef enum logic [12:0] {
    S_CLEAR    = 13'b0000000000001,
    S_IDLE     = 13'b0000000000010,
    S_HASH     = 13'b0000000000100,
    S_PREP     = 13'b0000000001000,
    S_PROBE_RD = 13'b0000000010000,
    S_PROBE    = 13'b0000000100000,
    S_RH_CLR   = 13'b0000001000000,
    S_RH_RD    = 13'b0000010000000,
    S_RH_CHK   = 13'b0000100000000,
    S_RH_HASH  = 13'b0001000000000,
    S_RH_PRD   = 13'b0010000000000,
    S_RH_PCHK  = 13'b0100000000000,
    S_DONE     = 13'b1000000000000
  } state_e;

  state_e state_q, state_d;

  logic [ADDR_W-1:0] clr_q, clr_d;
  logic              bank_q, bank_d;
  logic [CNT_W-1:0]  entry_q, entry_d;
  logic [CNT_W-1:0]  tomb_q, tomb_d;
  logic              used_q, used_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [POS_W-1:0]  req_pos_q, req_pos_d;
  logic [POS_W-1:0]  n_q, n_d;
  logic [POS_W-1:0]  i_q, i_d;
  logic [POS_W-1:0]  free_q, free_d;
  logic              have_free_q, have_free_d;

  req_e                  req_q;
  logic [KEY_BITS-1:0]   key_q;
  logic [VALUE_BITS-1:0] val_q;
  logic [KEY_BITS-1:0]   rh_key_q;
  logic [VALUE_BITS-1:0] rh_val_q;
  logic                  rh_load;

  status_e          res_status_q, res_status_d;
  logic             res_found_q, res_found_d;
  logic [31:0]      res_val_q, res_val_d;

  logic             out_valid_q;
  status_e          out_status_q;
  logic             out_found_q;
  logic [31:0]      out_val_q;
  logic [9:0]       out_cnt_q;

  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  slot_t             wr_data;
  logic [ADDR_W-1:0] rd_addr;
  slot_t             rd_data;

  logic                mod_start;
  logic [KEY_BITS-1:0] mod_key;
  logic                mod_done;
  logic [POS_W-1:0]    mod_pos;

  logic              accept;
  logic              out_free;
  logic [POS_W-1:0]  pos_next;
  logic              is_insert;
  logic              key_hit;

  function automatic logic [ADDR_W-1:0] slot_addr(logic bank, logic [POS_W-1:0] pos);
    slot_addr = bank ? ADDR_W'(pos) + ADDR_W'(SLOTS) : ADDR_W'(pos);
  endfunction

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign pos_next   = (pos_q == POS_W'(SLOTS - 1)) ? '0 : pos_q + POS_W'(1);
  assign is_insert  = (req_q == REQ_INSERT);
  assign key_hit    = (rd_data.tag == TAG_LIVE) && (rd_data.key == key_q);

  assign mod_start = accept || rh_load;
  assign mod_key   = accept ? key_i : rd_data.key;

  lpht_mod u_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mod_start),
    .key_i   (mod_key),
    .done_o  (mod_done),
    .pos_o   (mod_pos)
  );

  lpht_ram #(
    .Width (SLOT_W),
    .Depth (DEPTH)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    bank_d       = bank_q;
    entry_d      = entry_q;
    tomb_d       = tomb_q;
    used_d       = used_q;
    pos_d        = pos_q;
    req_pos_d    = req_pos_q;
    n_d          = n_q;
    i_d          = i_q;
    free_d       = free_q;
    have_free_d  = have_free_q;
    res_status_d = res_status_q;
    res_found_d  = res_found_q;
    res_val_d    = res_val_q;
    rh_load      = 1'b0;
    wr_en        = 1'b0;
    wr_addr      = slot_addr(bank_q, pos_q);
    wr_data      = '{tag: TAG_EMPTY, key: '0, val: '0};
    rd_addr      = slot_addr(bank_q, pos_q);

    case (state_q)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_q;
        clr_d   = clr_q + ADDR_W'(1);
        if (clr_q == ADDR_W'(DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          res_status_d = ST_OK;
          res_found_d  = 1'b0;
          res_val_d    = '0;
          state_d      = S_HASH;
        end
      end
      S_HASH: begin
        if (mod_done) begin
          pos_d     = mod_pos;
          req_pos_d = mod_pos;
          state_d   = S_PREP;
        end
      end
      S_PREP: begin
        if (is_insert) begin
          used_d = 1'b1;
          if ((CNT_W + 1)'(entry_q) + (CNT_W + 1)'(tomb_q) > (CNT_W + 1)'(HALF)) begin
            i_d     = '0;
            state_d = S_RH_CLR;
          end else if (entry_q > CNT_W'(HALF)) begin
            res_status_d = ST_FULL;
            state_d      = S_DONE;
          end else begin
            state_d = S_PROBE_RD;
          end
        end else if (!used_q) begin
          res_status_d = ST_UNUSED;
          state_d      = S_DONE;
        end else begin
          state_d = S_PROBE_RD;
        end
      end
      S_PROBE_RD: begin
        n_d         = '0;
        have_free_d = 1'b0;
        state_d     = S_PROBE;
      end
      S_PROBE: begin
        // The read of the next slot goes out while this slot is checked.
        rd_addr = slot_addr(bank_q, pos_next);
        if (rd_data.tag == TAG_EMPTY) begin
          if (is_insert) begin
            wr_en   = 1'b1;
            wr_addr = slot_addr(bank_q, have_free_q ? free_q : pos_q);
            wr_data = '{tag: TAG_LIVE, key: key_q, val: val_q};
            entry_d = entry_q + CNT_W'(1);
            if (have_free_q && tomb_q != '0) begin
              tomb_d = tomb_q - CNT_W'(1);
            end
          end else begin
            res_status_d = ST_NOT_FOUND;
          end
          state_d = S_DONE;
        end else if (key_hit) begin
          if (is_insert) begin
            res_status_d = ST_DUPLICATE;
          end else if (req_q == REQ_REMOVE) begin
            wr_en   = 1'b1;
            wr_data = '{tag: TAG_TOMB, key: rd_data.key, val: rd_data.val};
            if (entry_q != '0) begin
              entry_d = entry_q - CNT_W'(1);
            end
            tomb_d = tomb_q + CNT_W'(1);
          end else begin
            res_found_d = 1'b1;
            res_val_d   = 32'(rd_data.val);
          end
          state_d = S_DONE;
        end else begin
          if (rd_data.tag == TAG_TOMB && !have_free_q) begin
            have_free_d = 1'b1;
            free_d      = pos_q;
          end
          if (n_q == POS_W'(SLOTS - 1)) begin
            // Every slot was visited without meeting an empty one.
            if (is_insert) begin
              if (have_free_q || rd_data.tag == TAG_TOMB) begin
                wr_en   = 1'b1;
                wr_addr = slot_addr(bank_q, have_free_q ? free_q : pos_q);
                wr_data = '{tag: TAG_LIVE, key: key_q, val: val_q};
                entry_d = entry_q + CNT_W'(1);
                if (tomb_q != '0) begin
                  tomb_d = tomb_q - CNT_W'(1);
                end
              end else begin
                res_status_d = ST_FULL;
              end
            end else begin
              res_status_d = ST_NOT_FOUND;
            end
            state_d = S_DONE;
          end else begin
            n_d   = n_q + POS_W'(1);
            pos_d = pos_next;
          end
        end
      end
      S_RH_CLR: begin
        wr_en   = 1'b1;
        wr_addr = slot_addr(!bank_q, i_q);
        i_d     = i_q + POS_W'(1);
        if (i_q == POS_W'(SLOTS - 1)) begin
          i_d     = '0;
          state_d = S_RH_RD;
        end
      end
      S_RH_RD: begin
        rd_addr = slot_addr(bank_q, i_q);
        state_d = S_RH_CHK;
      end
      S_RH_CHK: begin
        if (rd_data.tag == TAG_LIVE) begin
          rh_load = 1'b1;
          state_d = S_RH_HASH;
        end else if (i_q == POS_W'(SLOTS - 1)) begin
          bank_d = !bank_q;
          tomb_d = '0;
          pos_d  = req_pos_q;
          if (entry_q > CNT_W'(HALF)) begin
            res_status_d = ST_FULL;
            state_d      = S_DONE;
          end else begin
            state_d = S_PROBE_RD;
          end
        end else begin
          i_d     = i_q + POS_W'(1);
          state_d = S_RH_RD;
        end
      end
      S_RH_HASH: begin
        if (mod_done) begin
          pos_d   = mod_pos;
          state_d = S_RH_PRD;
        end
      end
      S_RH_PRD: begin
        rd_addr = slot_addr(!bank_q, pos_q);
        state_d = S_RH_PCHK;
      end
      S_RH_PCHK: begin
        if (rd_data.tag == TAG_LIVE) begin
          pos_d   = pos_next;
          state_d = S_RH_PRD;
        end else begin
          wr_en   = 1'b1;
          wr_addr = slot_addr(!bank_q, pos_q);
          wr_data = '{tag: TAG_LIVE, key: rh_key_q, val: rh_val_q};
          // Resume the source scan; after the last slot, rh_last_move ends the rebuild.
          state_d = S_RH_CHK;
          if (i_q == POS_W'(SLOTS - 1)) begin
            state_d = S_RH_CHK;
          end else begin
            i_d     = i_q + POS_W'(1);
            state_d = S_RH_RD;
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // After the last source slot is moved, finish the rebuild directly.
  logic rh_last_move;
  assign rh_last_move = (state_q == S_RH_PCHK) && (rd_data.tag != TAG_LIVE) &&
                        (i_q == POS_W'(SLOTS - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      bank_q      <= 1'b0;
      entry_q     <= '0;
      tomb_q      <= '0;
      used_q      <= 1'b0;
      have_free_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      clr_q       <= clr_d;
      entry_q     <= entry_d;
      used_q      <= used_d;
      have_free_q <= have_free_d;
      if (rh_last_move) begin
        bank_q <= !bank_q;
        tomb_q <= '0;
        if (entry_q > CNT_W'(HALF)) begin
          state_q <= S_DONE;
        end else begin
          state_q <= S_PROBE_RD;
        end
      end else begin
        bank_q  <= bank_d;
        tomb_q  <= tomb_d;
        state_q <= state_d;
      end
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q     <= rh_last_move ? req_pos_q : pos_d;
    req_pos_q <= req_pos_d;
    n_q       <= n_d;
    i_q       <= i_d;
    free_q    <= free_d;
    res_found_q <= res_found_d;
    res_val_q   <= res_val_d;
    if (rh_last_move && entry_q > CNT_W'(HALF)) begin
      res_status_q <= ST_FULL;
    end else begin
      res_status_q <= res_status_d;
    end
    if (accept) begin
      req_q <= (req_type_i == REQ_LOOKUP_ALT) ? REQ_LOOKUP : req_e'(req_type_i);
      key_q <= key_i;
      val_q <= value_i;
    end
    if (rh_load) begin
      rh_key_q <= rd_data.key;
      rh_val_q <= rd_data.val;
    end
    if (state_q == S_DONE && out_free) begin
      out_status_q <= res_status_q;
      out_found_q  <= res_found_q;
      out_val_q    <= res_val_q;
      out_cnt_q    <= entry_q[9:0];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign found_o      = out_found_q;
  assign value_out_o  = out_val_q;
  assign live_count_o = out_cnt_q;

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("state register is not one-hot");

  a_entry_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    entry_q <= CNT_W'(HALF + 1))
    else $error("live entry count above the refusal limit");

  a_clear_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> !out_valid_q)
    else $error("result presented during the reset clearing pass");

  a_rebuild_no_tomb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rh_last_move) |-> (tomb_q == '0))
    else $error("tombstones left after a rebuild");

endmodule
